/* sv/srt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted record table: shared definitions
// Widths, table capacity, status and command codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

   // table capacity and derived widths
   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // field widths
   localparam int KEY_W    = 32;
   localparam int SCORE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // datapath sweep selector
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SCAN  = 2'd1,
      PH_SHIFT = 2'd2,
      PH_EMIT  = 2'd3
   } phase_type;

   // one stored record
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;         // capture the request
      phase_type  phase;        // sweep that runs this cycle
      phase_type  start_phase;  // initialize pointers for this sweep
      logic       set_status;
      status_type status;
      logic       commit;       // write an inserted record and apply the insert or delete to the count
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_insert;
      logic is_empty;
      logic is_full;
      logic scan_done;
      logic scan_hit;
      logic shift_done;
      logic emit_done;
   } dp_stat_type;

endpackage

/* sv/srt_if.sv */
// ----------------------------------------------------------------------------
// Sorted record table: channel interfaces
// Valid/ready channels for commands (request) and listing results (response).
// ----------------------------------------------------------------------------
interface srt_req_if import srt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [KEY_W-1:0] key;
   logic [SCORE_W-1:0] score;

   modport source (output valid, output cmd, output key, output score, input ready);
   modport sink   (input valid, input cmd, input key, input score, output ready);
endinterface

interface srt_rsp_if import srt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic                    has_entry;
   logic signed [KEY_W-1:0] entry_key;
   logic [SCORE_W-1:0]      entry_score;
   logic                    is_last;
   logic [COUNT_W-1:0]      count;

   modport source (output valid, output status, output has_entry, output entry_key,
                   output entry_score, output is_last, output count, input ready);
   modport sink   (input valid, input status, input has_entry, input entry_key,
                   input entry_score, input is_last, input count, output ready);
endinterface

/* sv/srt_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted record table: controller
// Sequences one command: capture, decide, scan for position and shift the
// table where the command needs them, then stream the listing.
// ----------------------------------------------------------------------------
module srt_ctrl import srt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECIDE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_insert && stat.is_full) begin
               cmd.set_status  = 1'b1;
               cmd.status      = ST_FULL;
               cmd.start_phase = PH_EMIT;
               state_in        = S_EMIT;
            end else if (!stat.is_insert && stat.is_empty) begin
               cmd.set_status  = 1'b1;
               cmd.status      = ST_EMPTY;
               cmd.start_phase = PH_EMIT;
               state_in        = S_EMIT;
            end else if (stat.is_insert && stat.is_empty) begin
               // first record goes straight to slot zero
               cmd.set_status  = 1'b1;
               cmd.status      = ST_OK;
               cmd.commit      = 1'b1;
               cmd.start_phase = PH_EMIT;
               state_in        = S_EMIT;
            end else begin
               cmd.start_phase = PH_SCAN;
               state_in        = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.phase = PH_SCAN;
            if (stat.scan_done) begin
               if (stat.is_insert || stat.scan_hit) begin
                  cmd.set_status  = 1'b1;
                  cmd.status      = ST_OK;
                  cmd.start_phase = PH_SHIFT;
                  state_in        = S_SHIFT;
               end else begin
                  cmd.set_status  = 1'b1;
                  cmd.status      = ST_NOT_FOUND;
                  cmd.start_phase = PH_EMIT;
                  state_in        = S_EMIT;
               end
            end
         end
         S_SHIFT: begin
            cmd.phase = PH_SHIFT;
            if (stat.shift_done) begin
               cmd.commit      = 1'b1;
               cmd.start_phase = PH_EMIT;
               state_in        = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.phase = PH_EMIT;
            if (stat.emit_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/srt_dpath.sv */
// ----------------------------------------------------------------------------
// Sorted record table: datapath
// Record memory with registered read, sweep pointers, key compare and the
// response output register.
// ----------------------------------------------------------------------------
module srt_dpath import srt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_cmd,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [SCORE_W-1:0]      req_score,
   input  ctl_cmd_type             cmd,
   output dp_stat_type             stat,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_has_entry,
   output logic [KEY_W-1:0]        rsp_entry_key,
   output logic [SCORE_W-1:0]      rsp_entry_score,
   output logic                    rsp_is_last,
   output logic [COUNT_W-1:0]      rsp_count
);

   // record memory, one write and one registered read per cycle
   entry_type rec_mem [CAPACITY];
   entry_type rd_data_ff;

   // command context
   logic       op_ff, op_in;
   entry_type  req_ff, req_in;
   status_type status_ff, status_in;

   // table and sweep state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0] ra_ff, ra_in;       // address held in rd_data_ff
   logic              pend_ff, pend_in;   // rd_data_ff holds an unused read
   logic              empty_todo_ff, empty_todo_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   logic       out_has_ff, out_has_in;
   entry_type  out_entry_ff, out_entry_in;
   logic       out_last_ff, out_last_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   // memory port controls
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   entry_type         wr_data;

   // helpers
   logic             is_insert;
   logic             match;
   logic             ra_is_last;
   logic             ptr_below;
   logic             out_free;
   logic             move;
   logic [CNT_W-1:0] ptr_inc, ptr_dec;

   assign is_insert  = (op_ff == CMD_INSERT);
   assign ptr_inc    = ptr_ff + CNT_W'(1);
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign ptr_below  = (ptr_ff < count_ff);
   assign ra_is_last = ((CNT_W'(ra_ff) + CNT_W'(1)) == count_ff);
   assign out_free   = !out_valid_ff || rsp_ready;
   assign move       = pend_ff && out_free;

   // insert stops at the first key >= new key, delete at the first equal key
   assign match = is_insert ? !($signed(rd_data_ff.key) < $signed(req_ff.key))
                            : (rd_data_ff.key == req_ff.key);

   // sweep, commit and output control
   always_comb begin
      op_in         = op_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      ra_in         = ra_ff;
      pend_in       = pend_ff;
      empty_todo_in = empty_todo_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_has_in    = out_has_ff;
      out_entry_in  = out_entry_ff;
      out_last_in   = out_last_ff;
      out_count_in  = out_count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;
      stat          = '0;

      stat.is_insert = is_insert;
      stat.is_empty  = (count_ff == '0);
      stat.is_full   = (count_ff == CNT_W'(CAPACITY));

      // capture the command
      if (cmd.load) begin
         op_in        = req_cmd;
         req_in.key   = req_key;
         req_in.score = req_score;
         pos_in       = '0;
      end

      if (cmd.set_status) begin
         status_in = cmd.status;
      end

      // a response transfer frees the output register
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (cmd.phase)
         PH_SCAN: begin
            // walk forward, compare each record in the cycle after its read
            if (ptr_below) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[ADDR_W-1:0];
               ptr_in  = ptr_inc;
               ra_in   = ptr_ff[ADDR_W-1:0];
            end
            pend_in = rd_en;
            if (pend_ff && (match || ra_is_last)) begin
               stat.scan_done = 1'b1;
               stat.scan_hit  = match;
               pos_in         = match ? CNT_W'(ra_ff) : count_ff;
            end
         end
         PH_SHIFT: begin
            if (is_insert) begin
               // move records at pos and above up by one, top first
               if (ptr_ff > pos_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_dec[ADDR_W-1:0];
                  ptr_in  = ptr_dec;
                  ra_in   = ptr_dec[ADDR_W-1:0];
               end
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = ra_ff + ADDR_W'(1);
               end
               stat.shift_done = (ptr_ff == pos_ff) && !pend_ff;
            end else begin
               // move records above pos down by one, bottom first
               if (ptr_below) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff[ADDR_W-1:0];
                  ptr_in  = ptr_inc;
                  ra_in   = ptr_ff[ADDR_W-1:0];
               end
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = ra_ff - ADDR_W'(1);
               end
               stat.shift_done = !ptr_below && !pend_ff;
            end
            pend_in = rd_en;
         end
         PH_EMIT: begin
            // read ahead while the read register is free or draining
            if (ptr_below && (!pend_ff || move)) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[ADDR_W-1:0];
               ptr_in  = ptr_inc;
               ra_in   = ptr_ff[ADDR_W-1:0];
            end
            pend_in = rd_en || (pend_ff && !move);
            if (move) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_has_in    = 1'b1;
               out_entry_in  = rd_data_ff;
               out_last_in   = ra_is_last;
               out_count_in  = COUNT_W'(count_ff);
            end else if (empty_todo_ff && out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_has_in    = 1'b0;
               out_entry_in  = '0;
               out_last_in   = 1'b1;
               out_count_in  = COUNT_W'(count_ff);
               empty_todo_in = 1'b0;
            end
            stat.emit_done = !empty_todo_ff && !ptr_below && !pend_ff;
         end
         default: begin
         end
      endcase

      // apply the table change
      if (cmd.commit) begin
         if (is_insert) begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[ADDR_W-1:0];
            wr_data  = req_ff;
            count_in = count_ff + CNT_W'(1);
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      // sweep start overrides the running sweep
      case (cmd.start_phase)
         PH_SCAN: begin
            ptr_in  = '0;
            pend_in = 1'b0;
         end
         PH_SHIFT: begin
            ptr_in  = is_insert ? count_ff : (pos_in + CNT_W'(1));
            pend_in = 1'b0;
         end
         PH_EMIT: begin
            ptr_in        = '0;
            pend_in       = 1'b0;
            empty_todo_in = (count_in == '0);
         end
         default: begin
         end
      endcase
   end

   // record memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rec_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         empty_todo_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         empty_todo_ff <= empty_todo_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      req_ff        <= req_in;
      status_ff     <= status_in;
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      ra_ff         <= ra_in;
      out_status_ff <= out_status_in;
      out_has_ff    <= out_has_in;
      out_entry_ff  <= out_entry_in;
      out_last_ff   <= out_last_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_has_entry   = out_has_ff;
   assign rsp_entry_key   = out_entry_ff.key;
   assign rsp_entry_score = out_entry_ff.score;
   assign rsp_is_last     = out_last_ff;
   assign rsp_count       = out_count_ff;

endmodule

/* sv/sorted_record_table_unit.sv */
// ----------------------------------------------------------------------------
// Sorted record table unit
// Keeps up to CAPACITY (key, score) records in ascending signed key order,
// inserts or deletes one record per command and lists the table after each.
//
//   channel | dir | transfer carries
//   --------+-----+-----------------------------------------------------------
//   req_if  | in  | cmd, key, score
//   rsp_if  | out | status, has_entry, entry_key, entry_score, is_last, count
//
// One command at a time. A command may run a forward scan of the record memory
// up to the position and a shift of the records behind it (together one pass
// over the table), then the listing at one record per cycle while the
// receiver is ready; response stalls lengthen the listing. Synchronous
// reset empties the table; the memory needs no clearing.
// The last listed record may still wait in the output register while the
// next command is accepted.
// ----------------------------------------------------------------------------
module sorted_record_table_unit import srt_pkg::*; (
   input logic    clock,
   input logic    reset,
   srt_req_if.sink   req_if,
   srt_rsp_if.source rsp_if
);

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   // command sequencer
   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   // record storage and listing path
   srt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_if.cmd),
      .req_key         (req_if.key),
      .req_score       (req_if.score),
      .cmd             (ctl_cmd),
      .stat            (dp_stat),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_has_entry   (rsp_if.has_entry),
      .rsp_entry_key   (rsp_if.entry_key),
      .rsp_entry_score (rsp_if.entry_score),
      .rsp_is_last     (rsp_if.is_last),
      .rsp_count       (rsp_if.count)
   );

endmodule

/* dv/tb_sorted_record_table_unit.sv */
// ----------------------------------------------------------------------------
// Sorted record table unit: testbench
// Sends insert and delete commands and checks each listing transfer against
// an in-bench model of the ordered table. The model runs when a command is
// accepted. A short directed run covers the key extremes, equal keys, a
// missing key, a delete on an empty table and the empty listing. The random
// run then repeats rounds of fill (past full), churn and drain, while the
// sender and receiver stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_record_table_unit;
   import srt_pkg::*;

   localparam int RANDOM_CMDS  = 190;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;

   // one expected listing transfer
   typedef struct {
      status_type              status;
      logic                    has_entry;
      logic signed [KEY_W-1:0] entry_key;
      logic [SCORE_W-1:0]      entry_score;
      logic                    is_last;
      logic [COUNT_W-1:0]      count;
   } listing_entry_type;

   // ordered table model plus the queue of listing transfers still owed
   class record_table_scoreboard;
      logic signed [KEY_W-1:0] keys[CAPACITY];
      logic [SCORE_W-1:0]      scores[CAPACITY];
      int                      stored = 0;
      listing_entry_type       expected_q[$];
      int                      error_count = 0;

      // update the table for an accepted command and queue its listing
      function void note_command(logic cmd, logic signed [KEY_W-1:0] key,
                                 logic [SCORE_W-1:0] score);
         status_type        st;
         listing_entry_type ent;
         int                pos;
         int                i;
         pos = 0;
         if (cmd == CMD_INSERT) begin
            if (stored >= CAPACITY) begin
               st = ST_FULL;
            end else begin
               // new record goes in front of the first key >= its own
               while (pos < stored && keys[pos] < key) pos++;
               for (i = stored; i > pos; i--) begin
                  keys[i]   = keys[i-1];
                  scores[i] = scores[i-1];
               end
               keys[pos]   = key;
               scores[pos] = score;
               stored++;
               st = ST_OK;
            end
         end else begin
            if (stored == 0) begin
               st = ST_EMPTY;
            end else begin
               while (pos < stored && keys[pos] != key) pos++;
               if (pos >= stored) begin
                  st = ST_NOT_FOUND;
               end else begin
                  for (i = pos; i + 1 < stored; i++) begin
                     keys[i]   = keys[i+1];
                     scores[i] = scores[i+1];
                  end
                  stored--;
                  st = ST_OK;
               end
            end
         end

         ent.status = st;
         ent.count  = COUNT_W'(stored);
         if (stored == 0) begin
            ent.has_entry   = 1'b0;
            ent.entry_key   = '0;
            ent.entry_score = '0;
            ent.is_last     = 1'b1;
            expected_q.push_back(ent);
         end else begin
            for (i = 0; i < stored; i++) begin
               ent.has_entry   = 1'b1;
               ent.entry_key   = keys[i];
               ent.entry_score = scores[i];
               ent.is_last     = (i == stored - 1);
               expected_q.push_back(ent);
            end
         end
      endfunction

      // compare one listing transfer with the oldest expectation
      function void check_result(listing_entry_type got);
         listing_entry_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected listing transfer: key %0h score %0h",
                   got.entry_key, got.entry_score);
            error_count++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            error_count++;
         end
         if (got.has_entry !== exp.has_entry) begin
            $error("has_entry expected %0d actual %0d", exp.has_entry, got.has_entry);
            error_count++;
         end
         if (got.entry_key !== exp.entry_key) begin
            $error("entry_key expected %0h actual %0h", exp.entry_key, got.entry_key);
            error_count++;
         end
         if (got.entry_score !== exp.entry_score) begin
            $error("entry_score expected %0h actual %0h", exp.entry_score,
                   got.entry_score);
            error_count++;
         end
         if (got.is_last !== exp.is_last) begin
            $error("is_last expected %0d actual %0d", exp.is_last, got.is_last);
            error_count++;
         end
         if (got.count !== exp.count) begin
            $error("count expected %0d actual %0d", exp.count, got.count);
            error_count++;
         end
      endfunction

      // some key that is in the table, for deletes that hit
      function logic signed [KEY_W-1:0] stored_key_pick();
         if (stored == 0) return $urandom;
         return keys[$urandom_range(stored - 1)];
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count   = 0;
   int   commands_sent = 0;
   int   req_idle_pct  = 22;
   int   rsp_idle_pct  = 86;
   int   segment;

   record_table_scoreboard sb;

   srt_req_if req_if ();
   srt_rsp_if rsp_if ();

   sorted_record_table_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // listing monitor
   always @(posedge clock) begin
      listing_entry_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status      = status_type'(rsp_if.status);
         got.has_entry   = rsp_if.has_entry;
         got.entry_key   = rsp_if.entry_key;
         got.entry_score = rsp_if.entry_score;
         got.is_last     = rsp_if.is_last;
         got.count       = rsp_if.count;
         sb.check_result(got);
      end
   end

   // one command transfer; valid is left high for a back-to-back follow-up
   task automatic send_command(input logic cmd, input logic signed [KEY_W-1:0] key,
                               input logic [SCORE_W-1:0] score);
      // stall profile follows progress through the run
      if (commands_sent < 85) begin
         req_idle_pct = 22;
         rsp_idle_pct = 86;
      end else if (commands_sent < 170) begin
         req_idle_pct = 86;
         rsp_idle_pct = 22;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         req_if.cmd   <= 1'($urandom_range(1));
         req_if.key   <= $urandom;
         req_if.score <= $urandom;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= cmd;
      req_if.key   <= key;
      req_if.score <= score;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_command(cmd, key, score);
      commands_sent++;
   endtask

   // random command; insert_pct sets the insert/delete mix
   task automatic send_random(input int insert_pct);
      logic signed [KEY_W-1:0] key;
      logic [SCORE_W-1:0]      score;
      logic                    cmd;
      cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
      case ($urandom_range(9))
         0, 1, 2: key = $signed(32'($urandom_range(8))) - 4;   // dense, many equal keys
         3: begin
            case ($urandom_range(3))
               0: key = 32'sh8000_0000;
               1: key = 32'sh7FFF_FFFF;
               2: key = 32'sh0000_0000;
               default: key = -32'sd1;
            endcase
         end
         default: key = $urandom;
      endcase
      // deletes mostly hit a stored key
      if (cmd == CMD_DELETE && $urandom_range(99) < 80) key = sb.stored_key_pick();
      case ($urandom_range(9))
         0: score = 32'h0000_0000;
         1: score = 32'hFFFF_FFFF;
         2: score = ($urandom_range(1) != 0) ? 32'h7F80_0000 : 32'h8000_0000;
         default: score = $urandom;
      endcase
      send_command(cmd, key, score);
   endtask

   initial begin
      sb           = new;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_INSERT;
      req_if.key   = '0;
      req_if.score = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // delete on an empty table
      send_command(CMD_DELETE, 32'sd5, 32'h1234_5678);
      // key extremes and payload extremes
      send_command(CMD_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'sh8000_0000, 32'h0000_0000);
      send_command(CMD_INSERT, 32'sd0, 32'h3F80_0000);
      send_command(CMD_INSERT, -32'sd1, 32'h8000_0000);
      // equal keys: each new one lands in front of the older ones
      send_command(CMD_INSERT, 32'sd0, 32'h4000_0000);
      send_command(CMD_INSERT, 32'sd0, 32'h4040_0000);
      // delete takes only the first of the equal keys
      send_command(CMD_DELETE, 32'sd0, 32'h0000_0000);
      // key not found, including a neighbor of stored keys
      send_command(CMD_DELETE, 32'sd12345, 32'h0000_0000);
      send_command(CMD_DELETE, 32'sd1, 32'hFFFF_FFFF);
      send_command(CMD_INSERT, 32'sd1, 32'h5555_5555);
      send_command(CMD_DELETE, 32'sh8000_0000, 32'hAAAA_AAAA);
      send_command(CMD_DELETE, 32'sh7FFF_FFFF, 32'h0000_0000);
      // payload is ignored on delete
      send_command(CMD_DELETE, -32'sd1, 32'hDEAD_BEEF);
      // drain to the empty listing, then delete on empty again
      send_command(CMD_DELETE, 32'sd0, 32'h0000_0000);
      send_command(CMD_DELETE, 32'sd0, 32'h0000_0000);
      send_command(CMD_DELETE, 32'sd1, 32'h0000_0000);
      send_command(CMD_DELETE, 32'sd0, 32'h0000_0000);

      // rounds of fill past full, churn, and drain to empty
      segment = 0;
      while (commands_sent < 18 + RANDOM_CMDS) begin
         case (segment % 3)
            0: begin
               while (sb.stored < CAPACITY) send_random(90);
               repeat ($urandom_range(3, 1)) send_random(100);
            end
            1: repeat (20) send_random(50);
            default: begin
               while (sb.stored > 0) send_random(10);
               repeat ($urandom_range(2, 1)) send_random(0);
            end
         endcase
         segment++;
      end
      req_if.valid <= 1'b0;

      // wait out the remaining listing transfers
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
sv/srt_pkg.sv
sv/srt_if.sv
sv/srt_ctrl.sv
sv/srt_dpath.sv
sv/sorted_record_table_unit.sv
dv/tb_sorted_record_table_unit.sv
